[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/sgpt_pkg.sv]
package sgpt_pkg;

  localparam int GROUP_W = 4;
  localparam int TICK_W  = 16;

  // Request codes
  localparam logic [2:0] REQ_TICK       = 3'd0;
  localparam logic [2:0] REQ_SET        = 3'd1;
  localparam logic [2:0] REQ_SET_PRESET = 3'd2;
  localparam logic [2:0] REQ_QUERY      = 3'd3;
  localparam logic [2:0] REQ_FAULT      = 3'd4;
  localparam logic [2:0] REQ_LOAD       = 3'd5;

  // Signal group state codes
  localparam logic [2:0] ST_AMBER       = 3'd1;
  localparam logic [2:0] ST_MIN_RED     = 3'd2;
  localparam logic [2:0] ST_EXT_RED     = 3'd3;
  localparam logic [2:0] ST_PREP        = 3'd4;
  localparam logic [2:0] ST_MIN_GREEN   = 3'd5;
  localparam logic [2:0] ST_EXT_GREEN   = 3'd6;
  localparam logic [2:0] ST_GREEN_BLINK = 3'd7;

  // Fault marks
  localparam logic [1:0] FAULT_OK     = 2'd0;
  localparam logic [1:0] FAULT_ON     = 2'd1;
  localparam logic [1:0] FAULT_ABSENT = 2'd2;

  // Result kinds
  localparam logic KIND_CMD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [TICK_W-1:0] PRESET_ELAPSED = 16'd200;
  localparam logic [TICK_W-1:0] ELAPSED_MAX    = 16'hFFFF;

  // Loaded durations of one group (blink: green blink, green_floor: minimum green)
  typedef struct packed {
    logic [TICK_W-1:0] green_floor;
    logic [TICK_W-1:0] prep;
    logic [TICK_W-1:0] min_red;
    logic [TICK_W-1:0] amber;
    logic [TICK_W-1:0] blink;
  } dur_t;

  // One result beat
  typedef struct packed {
    logic               kind;
    logic [GROUP_W-1:0] group;
    logic [2:0]         new_state;
    logic               in_state;
    logic [TICK_W-1:0]  elapsed;
    logic [1:0]         fault;
    logic               last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_STEP  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_QUERY = 5'b10000
  } fsm_t;

endpackage

[src/signal_group_phase_timer.sv]
// Signal group phase timer.
// Set state, set fault and load are written while the block stays idle; a query answer is registered
// from the answer state once the output is free. A tick walks the groups with one shared compare,
// fetching and stepping each group one state move at a time, then flushing; out_stall can hold it.
// One item at a time; in_stall is high until the item is done.
// Synchronous reset clears states, counts, faults and present bits; durations are not.
`include "assert_macros.svh"

module signal_group_phase_timer
  import sgpt_pkg::*;
#(
  parameter int NUM_GROUPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [GROUP_W-1:0] in_group,
  input  logic [2:0]         in_state_code,
  input  logic               in_fault_flag,
  input  logic               in_exists,
  input  logic [TICK_W-1:0]  in_green_blink_ticks,
  input  logic [TICK_W-1:0]  in_amber_ticks,
  input  logic [TICK_W-1:0]  in_min_red_ticks,
  input  logic [TICK_W-1:0]  in_prep_ticks,
  input  logic [TICK_W-1:0]  in_min_green_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [GROUP_W-1:0] out_group,
  output logic [2:0]         out_new_state,
  output logic               out_in_state,
  output logic [TICK_W-1:0]  out_elapsed,
  output logic [1:0]         out_fault,
  output logic               out_last
);

  localparam int IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam logic [GROUP_W:0] NUM_G   = (GROUP_W+1)'(NUM_GROUPS);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(NUM_GROUPS - 1);

  // Per-group state
  logic [2:0]        state_r   [NUM_GROUPS];
  logic [TICK_W-1:0] elapsed_r [NUM_GROUPS];
  logic [1:0]        fault_r   [NUM_GROUPS];
  logic              present_r [NUM_GROUPS];
  dur_t              dur_mem   [NUM_GROUPS];
  dur_t              dur_q_r;

  fsm_t fsm_r, fsm_nxt;
  logic [IDX_W-1:0]   walk_r, walk_nxt;
  logic [2:0]         cur_state_r, cur_state_nxt;
  logic [TICK_W-1:0]  cur_el_r, cur_el_nxt;
  logic               cur_pres_r;
  logic               pend_valid_r, pend_valid_nxt;
  logic [2:0]         pend_state_r, pend_state_nxt;
  logic [GROUP_W-1:0] pend_group_r, pend_group_nxt;
  logic [IDX_W-1:0]   grp_ix_r;
  logic [GROUP_W-1:0] grp_r;
  logic [2:0]         q_state_r;
  logic               q_ok_r;
  logic               out_valid_r;
  res_t               out_r;

  logic               in_acc;
  logic               in_ok;
  logic [IDX_W-1:0]   in_ix;
  logic [IDX_W-1:0]   sel_ix;
  logic               out_free;
  logic               push_en;
  res_t               push_d;
  logic               wb_en;
  logic [TICK_W-1:0]  el_inc;
  logic               timed;
  logic [TICK_W-1:0]  dur_sel;
  logic [2:0]         move_to;
  logic               gate;
  logic               mv;
  logic               q_hit;

  assign in_stall = (fsm_r != S_IDLE);
  assign in_acc   = in_valid && (fsm_r == S_IDLE);
  assign in_ok    = {1'b0, in_group} < NUM_G;
  assign in_ix    = in_group[IDX_W-1:0];
  assign sel_ix   = (fsm_r == S_QUERY) ? grp_ix_r : walk_r;
  assign out_free = !out_valid_r || !out_stall;

  // Saturating elapsed increment
  assign el_inc = (cur_el_r == ELAPSED_MAX) ? cur_el_r : cur_el_r + 1'b1;

  // Duration select for the current timed state
  always_comb begin
    timed   = 1'b1;
    dur_sel = dur_q_r.blink;
    move_to = ST_AMBER;
    gate    = (dur_q_r.amber != '0);
    case (cur_state_r)
      ST_GREEN_BLINK: begin
        dur_sel = dur_q_r.blink;
        move_to = ST_AMBER;
        gate    = (dur_q_r.amber != '0);
      end
      ST_AMBER: begin
        dur_sel = dur_q_r.amber;
        move_to = ST_MIN_RED;
        gate    = (dur_q_r.min_red != '0);
      end
      ST_MIN_RED: begin
        dur_sel = dur_q_r.min_red;
        move_to = ST_EXT_RED;
        gate    = 1'b1;
      end
      ST_PREP: begin
        dur_sel = dur_q_r.prep;
        move_to = ST_MIN_GREEN;
        gate    = (dur_q_r.green_floor != '0);
      end
      ST_MIN_GREEN: begin
        dur_sel = dur_q_r.green_floor;
        move_to = ST_EXT_GREEN;
        gate    = 1'b1;
      end
      default: timed = 1'b0;
    endcase
  end

  // Shared compare: elapsed reached duration
  assign mv    = timed && (cur_el_r >= dur_sel);
  assign q_hit = q_ok_r && (state_r[sel_ix] == q_state_r);

  // Sequencer
  always_comb begin
    fsm_nxt        = fsm_r;
    walk_nxt       = walk_r;
    cur_state_nxt  = cur_state_r;
    cur_el_nxt     = cur_el_r;
    pend_valid_nxt = pend_valid_r;
    pend_state_nxt = pend_state_r;
    pend_group_nxt = pend_group_r;
    push_en        = 1'b0;
    push_d         = '0;
    wb_en          = 1'b0;
    case (fsm_r)
      S_IDLE: begin
        if (in_acc && in_req_type == REQ_TICK) begin
          walk_nxt = '0;
          fsm_nxt  = S_FETCH;
        end else if (in_acc && in_req_type == REQ_QUERY) begin
          fsm_nxt = S_QUERY;
        end
      end
      S_FETCH: begin
        cur_state_nxt = state_r[walk_r];
        cur_el_nxt    = elapsed_r[walk_r];
        fsm_nxt       = S_STEP;
      end
      S_STEP: begin
        if (cur_pres_r && mv) begin
          // one cascade move; wait if the pending beat cannot leave
          if (!(gate && pend_valid_r && !out_free)) begin
            cur_state_nxt = move_to;
            cur_el_nxt    = '0;
            if (gate) begin
              push_en          = pend_valid_r;
              push_d.kind      = KIND_CMD;
              push_d.group     = pend_group_r;
              push_d.new_state = pend_state_r;
              pend_valid_nxt   = 1'b1;
              pend_state_nxt   = move_to;
              pend_group_nxt   = GROUP_W'(walk_r);
            end
          end
        end else begin
          wb_en = cur_pres_r;
          if (walk_r == LAST_IX) begin
            fsm_nxt = S_FLUSH;
          end else begin
            walk_nxt = walk_r + 1'b1;
            fsm_nxt  = S_FETCH;
          end
        end
      end
      S_FLUSH: begin
        // last command of the tick carries the last flag
        if (!pend_valid_r) begin
          fsm_nxt = S_IDLE;
        end else if (out_free) begin
          push_en          = 1'b1;
          push_d.kind      = KIND_CMD;
          push_d.group     = pend_group_r;
          push_d.new_state = pend_state_r;
          push_d.last      = 1'b1;
          pend_valid_nxt   = 1'b0;
          fsm_nxt          = S_IDLE;
        end
      end
      S_QUERY: begin
        if (out_free) begin
          push_en         = 1'b1;
          push_d.kind     = KIND_QUERY;
          push_d.group    = grp_r;
          push_d.in_state = q_hit;
          push_d.elapsed  = q_hit ? elapsed_r[sel_ix] : '0;
          push_d.fault    = q_ok_r ? fault_r[sel_ix] : FAULT_ABSENT;
          push_d.last     = 1'b1;
          fsm_nxt         = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fsm_r        <= fsm_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (push_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    cur_state_r  <= cur_state_nxt;
    cur_el_r     <= cur_el_nxt;
    pend_state_r <= pend_state_nxt;
    pend_group_r <= pend_group_nxt;
    if (fsm_r == S_FETCH) begin
      cur_pres_r <= present_r[walk_r];
    end
    if (in_acc) begin
      grp_ix_r  <= in_ix;
      grp_r     <= in_group;
      q_state_r <= in_state_code;
      q_ok_r    <= in_ok;
    end
    if (push_en) begin
      out_r <= push_d;
    end
  end

  // Group state arrays
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        state_r[i]   <= '0;
        elapsed_r[i] <= '0;
        fault_r[i]   <= FAULT_OK;
        present_r[i] <= 1'b0;
      end
    end else if (wb_en) begin
      state_r[walk_r]   <= cur_state_r;
      elapsed_r[walk_r] <= el_inc;
    end else if (in_acc && in_ok) begin
      case (in_req_type)
        REQ_SET: begin
          state_r[in_ix]   <= in_state_code;
          elapsed_r[in_ix] <= '0;
        end
        REQ_SET_PRESET: begin
          state_r[in_ix]   <= in_state_code;
          elapsed_r[in_ix] <= PRESET_ELAPSED;
        end
        REQ_FAULT: begin
          fault_r[in_ix] <= in_fault_flag ? FAULT_ON : FAULT_OK;
        end
        REQ_LOAD: begin
          present_r[in_ix] <= in_exists;
          if (!in_exists) begin
            fault_r[in_ix] <= FAULT_ABSENT;
          end
        end
        default: ;
      endcase
    end
  end

  // Duration memory: written by load, read once per walked group
  always_ff @(posedge clk) begin
    if (in_acc && in_ok && in_req_type == REQ_LOAD) begin
      dur_mem[in_ix] <= '{green_floor: in_min_green_ticks,
                          prep:        in_prep_ticks,
                          min_red:     in_min_red_ticks,
                          amber:       in_amber_ticks,
                          blink:       in_green_blink_ticks};
    end
    if (fsm_r == S_FETCH) begin
      dur_q_r <= dur_mem[walk_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_group     = out_r.group;
  assign out_new_state = out_r.new_state;
  assign out_in_state  = out_r.in_state;
  assign out_elapsed   = out_r.elapsed;
  assign out_fault     = out_r.fault;
  assign out_last      = out_r.last;

  // No command is left pending once the block is idle
  `ASSERT_IMPLIES(a_no_pend_idle, clk, rst_n, fsm_r == S_IDLE, !pend_valid_r)
  // A query beat always leads into the answer state
  `ASSERT_NEXT(a_query_seq, clk, rst_n, in_acc && in_req_type == REQ_QUERY, fsm_r == S_QUERY)
  // A tick beat always starts the group walk at the first group
  `ASSERT_NEXT(a_tick_seq, clk, rst_n, in_acc && in_req_type == REQ_TICK,
               fsm_r == S_FETCH && walk_r == '0)

endmodule
